// ----- src/rational_arithmetic_unit_core_defines.svh -----
// Assertion macros for the rational arithmetic unit.
// Used by the controller; no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rau assertion failed");
`define RAU_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rau assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst_n, a, b)
`define RAU_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- src/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    localparam int DEFAULT_OPERAND_WIDTH = 16;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        MSEL_P1 = 2'd0,
        MSEL_P2 = 2'd1,
        MSEL_P3 = 2'd2
    } t_msel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_CHECK,
        ST_GCD,
        ST_DIVI,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  load;
        logic  mul;
        t_msel mul_sel;
        logic  prep;
        logic  gcd_step;
        logic  div_init;
        logic  div_step;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic short_path;
        logic gcd_done;
        logic div_done;
    } t_status;

endpackage

// ----- src/rau_ctrl.sv -----
// Controller state machine of the rational arithmetic unit.
// Depends on rau_pkg and the assertion macro header.
`include "rational_arithmetic_unit_core_defines.svh"

module rau_ctrl
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_MUL0;
            ST_MUL0:  n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_PREP;
            ST_PREP:  n_state = ST_CHECK;
            ST_CHECK: n_state = i_status.short_path ? ST_DONE : ST_GCD;
            ST_GCD:   if (i_status.gcd_done) n_state = ST_DIVI;
            ST_DIVI:  n_state = ST_DIV;
            ST_DIV:   if (i_status.div_done) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.mul_sel = MSEL_P1;
        unique case (r_state)
            ST_IDLE:  o_cmd.load = start;
            ST_MUL0: begin
                o_cmd.mul = 1'b1;
                o_cmd.mul_sel = MSEL_P1;
            end
            ST_MUL1: begin
                o_cmd.mul = 1'b1;
                o_cmd.mul_sel = MSEL_P2;
            end
            ST_MUL2: begin
                o_cmd.mul = 1'b1;
                o_cmd.mul_sel = MSEL_P3;
            end
            ST_PREP:  o_cmd.prep = 1'b1;
            ST_CHECK: ;
            ST_GCD:   o_cmd.gcd_step = !i_status.gcd_done;
            ST_DIVI:  o_cmd.div_init = 1'b1;
            ST_DIV:   o_cmd.div_step = !i_status.div_done;
            ST_DONE:  o_cmd.emit = 1'b1;
            default:  ;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    `RAU_ASSERT_NXT(a_start_goes_busy, i_clk, i_rst_n, start && !busy, r_state == ST_MUL0)
    `RAU_ASSERT_NXT(a_done_to_idle, i_clk, i_rst_n, r_state == ST_DONE, r_state == ST_IDLE)
    `RAU_ASSERT_IMP(a_emit_once, i_clk, i_rst_n, o_cmd.emit, !o_cmd.div_step && !o_cmd.gcd_step)
    `RAU_ASSERT_IMP(a_short_skips, i_clk, i_rst_n,
        r_state == ST_CHECK && i_status.short_path, n_state == ST_DONE)

endmodule

// ----- src/rau_dp.sv -----
// Datapath of the rational arithmetic unit: multiplier, sign handling,
// binary gcd and two restoring dividers sharing one divisor. Uses rau_pkg.
module rau_dp
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cmd                            i_cmd,
    input  logic [2:0]                      i_opcode,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output t_status                         o_status,
    output logic                            o_valid,
    output logic signed [RES_NUM_W-1:0]     o_res_num,
    output logic [RES_DEN_W-1:0]            o_res_den,
    output logic signed [1:0]               o_order,
    output logic                            o_zero_den
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int SW = MW + 1;
    localparam int CW = $clog2(MW + 1);
    localparam int XW = (MW > RES_NUM_W) ? MW : RES_NUM_W + 1;

    logic [2:0]              r_op;
    logic signed [W-1:0]     r_an, r_ad, r_bn, r_bd;
    logic signed [MW-1:0]    r_p1, r_p2, r_p3;
    logic [MW-1:0]           r_num_mag, r_den_mag;
    logic                    r_num_neg, r_den_neg;
    logic signed [1:0]       r_order;
    logic [MW-1:0]           r_u, r_v;
    logic [CW-1:0]           r_k;
    logic [MW-1:0]           r_g;
    logic [MW-1:0]           r_qn, r_qd;
    logic [MW-1:0]           r_rn, r_rd;
    logic [CW-1:0]           r_cnt;
    logic                    r_valid;
    logic signed [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0]    r_res_den;
    logic signed [1:0]       r_res_order;
    logic                    r_res_zd;

    logic signed [W-1:0]     w_mx, w_my;
    logic signed [MW-1:0]    w_prod;
    logic signed [SW-1:0]    w_diff, w_sum, w_num;
    logic                    w_arith;
    logic [MW:0]             w_tn, w_td;
    logic [XW-1:0]           w_pmag, w_dx;
    logic                    w_pneg;
    logic signed [RES_NUM_W-1:0] w_pack;

    // operand pairs per product slot
    always_comb begin
        w_mx = r_an;
        w_my = r_bd;
        case (i_cmd.mul_sel)
            MSEL_P1: begin
                w_mx = r_an;
                w_my = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            MSEL_P2: begin
                w_mx = r_bn;
                w_my = r_ad;
            end
            default: begin
                w_mx = r_ad;
                w_my = (r_op == OP_DIV) ? r_bn : r_bd;
            end
        endcase
    end

    assign w_prod = w_mx * w_my;

    assign w_diff = SW'(r_p1) - SW'(r_p2);
    assign w_sum  = SW'(r_p1) + SW'(r_p2);
    always_comb begin
        case (r_op)
            OP_ADD:  w_num = w_sum;
            OP_SUB:  w_num = w_diff;
            default: w_num = SW'(r_p1);
        endcase
    end

    assign w_arith = (r_op == OP_ADD) || (r_op == OP_SUB) || (r_op == OP_MUL)
                     || (r_op == OP_DIV);

    assign o_status.short_path = !w_arith || (r_num_mag == '0) || (r_den_mag == '0);
    assign o_status.gcd_done   = (r_u == '0) || (r_v == '0);
    assign o_status.div_done   = (r_cnt == '0);

    assign w_tn = {r_rn, r_qn[MW-1]};
    assign w_td = {r_rd, r_qd[MW-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (i_cmd.mul) begin
            case (i_cmd.mul_sel)
                MSEL_P1: r_p1 <= w_prod;
                MSEL_P2: r_p2 <= w_prod;
                default: r_p3 <= w_prod;
            endcase
        end
        if (i_cmd.prep) begin
            r_num_neg <= w_num[SW-1];
            r_num_mag <= w_num[SW-1] ? MW'(-w_num) : MW'(w_num);
            r_den_neg <= r_p3[MW-1];
            r_den_mag <= r_p3[MW-1] ? MW'(-r_p3) : MW'(r_p3);
            r_u       <= w_num[SW-1] ? MW'(-w_num) : MW'(w_num);
            r_v       <= r_p3[MW-1] ? MW'(-r_p3) : MW'(r_p3);
            r_k       <= '0;
            // flip the ordering when the denominators disagree in sign
            if (w_diff == '0) begin
                r_order <= 2'sd0;
            end else if (w_diff[SW-1] ^ r_ad[W-1] ^ r_bd[W-1]) begin
                r_order <= -2'sd1;
            end else begin
                r_order <= 2'sd1;
            end
        end
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + CW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= (r_u | r_v) << r_k;
            r_qn  <= r_num_mag;
            r_qd  <= r_den_mag;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= CW'(MW);
        end
        if (i_cmd.div_step) begin
            if (w_tn >= {1'b0, r_g}) begin
                r_rn <= MW'(w_tn - {1'b0, r_g});
                r_qn <= {r_qn[MW-2:0], 1'b1};
            end else begin
                r_rn <= w_tn[MW-1:0];
                r_qn <= {r_qn[MW-2:0], 1'b0};
            end
            if (w_td >= {1'b0, r_g}) begin
                r_rd <= MW'(w_td - {1'b0, r_g});
                r_qd <= {r_qd[MW-2:0], 1'b1};
            end else begin
                r_rd <= w_td[MW-1:0];
                r_qd <= {r_qd[MW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // numerator to pack: unreduced on a zero denominator, else the quotient
    always_comb begin
        if (r_den_mag == '0) begin
            w_pneg = r_num_neg;
            w_pmag = XW'(r_num_mag);
        end else begin
            w_pneg = r_num_neg ^ r_den_neg;
            w_pmag = XW'(r_qn);
        end
        if (w_pneg) begin
            if (w_pmag > XW'(64'h8000_0000)) begin
                w_pack = 32'sh8000_0000;
            end else begin
                w_pack = RES_NUM_W'(XW'(0) - w_pmag);
            end
        end else begin
            if (w_pmag > XW'(64'h7FFF_FFFF)) begin
                w_pack = 32'sh7FFF_FFFF;
            end else begin
                w_pack = w_pmag[RES_NUM_W-1:0];
            end
        end
    end

    assign w_dx = XW'(r_qd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_res_num   <= '0;
            r_res_den   <= '0;
            r_res_order <= 2'sd0;
            r_res_zd    <= 1'b0;
            if (r_op == OP_CMP) begin
                r_res_order <= r_order;
            end else if (w_arith) begin
                if (r_num_mag == '0) begin
                    r_res_den <= RES_DEN_W'(1);
                end else if (r_den_mag == '0) begin
                    r_res_num <= w_pack;
                    r_res_zd  <= 1'b1;
                end else begin
                    r_res_num <= w_pack;
                    r_res_den <= (w_dx > XW'(64'h3FFF_FFFF)) ? 30'h3FFF_FFFF
                                                             : w_dx[RES_DEN_W-1:0];
                end
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_order    = r_res_order;
    assign o_zero_den = r_res_zd;

endmodule

// ----- src/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit: add, subtract, multiply, divide and compare of
// two signed fractions, with the result reduced by the gcd.
// Raise start with opcode and operands on i_opcode, i_a_num, i_a_den,
// i_b_num and i_b_den; the item is taken at the edge where start is high
// and busy is low. busy stays high until the result is produced.
// The result appears on o_res_num, o_res_den, o_order and o_zero_den for
// exactly one cycle with o_valid high; the receiver must take it then, as
// it cannot stall the block. A new item may be started in that same cycle.
// Compare, invalid opcodes, zero numerators and zero denominators take the
// short path (three products on one shared multiplier, sign handling,
// check, output register). Otherwise add the binary gcd, one step per
// cycle, the divider set-up state and the restoring division, which forms
// both quotients in parallel. For a reduced result the gcd loop and the
// bit-serial divider set the time.
// Synchronous reset returns the controller to idle and clears o_valid.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_opcode,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                            o_valid,
    output logic signed [RES_NUM_W-1:0]     o_res_num,
    output logic [RES_DEN_W-1:0]            o_res_den,
    output logic signed [1:0]               o_order,
    output logic                            o_zero_den
);

    t_cmd    w_cmd;
    t_status w_status;

    rau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    rau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_opcode   (i_opcode),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_status   (w_status),
        .o_valid    (o_valid),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_order    (o_order),
        .o_zero_den (o_zero_den)
    );

endmodule
